// ===== hw/rtl/bfa_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// bfa_pkg
// Shared types and constants of the bit-field ALU: operation codes, word
// sizes and the request/response payload structs.
// ----------------------------------------------------------------------------
package bfa_pkg;

  localparam int WORD_W = 64;
  localparam int HALF_W = 32;
  localparam int FUNC_W = 4;
  localparam int POS_W  = 7;

  typedef enum logic [FUNC_W-1:0] {
    FN_AND     = 4'd0,
    FN_OR      = 4'd1,
    FN_XOR     = 4'd2,
    FN_NOT     = 4'd3,
    FN_COUNT   = 4'd4,
    FN_EXTRACT = 4'd5,
    FN_GET     = 4'd6,
    FN_SET     = 4'd7,
    FN_REPLACE = 4'd8,
    FN_SHL     = 4'd9,
    FN_SHR     = 4'd10,
    FN_SAR     = 4'd11
  } bfa_func_t;

  typedef struct packed {
    logic [FUNC_W-1:0] func;
    logic              wide;
    logic [WORD_W-1:0] operand_a;
    logic [WORD_W-1:0] operand_b;
    logic [POS_W-1:0]  bit_position;
    logic [POS_W-1:0]  field_width;
    logic              bit_value;
  } bfa_req_t;

  typedef struct packed {
    logic [WORD_W-1:0] result;
    logic              range_error;
  } bfa_rsp_t;

endpackage
`default_nettype wire

// ===== hw/rtl/bfa_chan_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// bfa channel interfaces
// Valid/ready channels of the bit-field ALU: one for requests, one for
// responses.
// ----------------------------------------------------------------------------
interface bfa_in_if
  import bfa_pkg::*;
;
  logic              valid;
  logic              ready;
  logic [FUNC_W-1:0] func;
  logic              wide;
  logic [WORD_W-1:0] operand_a;
  logic [WORD_W-1:0] operand_b;
  logic [POS_W-1:0]  bit_position;
  logic [POS_W-1:0]  field_width;
  logic              bit_value;

  modport source (
    output valid, func, wide, operand_a, operand_b, bit_position, field_width,
           bit_value,
    input  ready
  );
  modport sink (
    input  valid, func, wide, operand_a, operand_b, bit_position, field_width,
           bit_value,
    output ready
  );
endinterface

interface bfa_out_if
  import bfa_pkg::*;
;
  logic              valid;
  logic              ready;
  logic [WORD_W-1:0] result;
  logic              range_error;

  modport source (output valid, result, range_error, input ready);
  modport sink (input valid, result, range_error, output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/bit_field_alu.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// bit_field_alu
// Bit-manipulation ALU: logic ops, population count, field extract/replace,
// single-bit get/set and shifts on 32- or 64-bit words.
// ----------------------------------------------------------------------------
// Usage:
//   in_req  : valid/ready request channel carrying func, wide, both operands,
//             bit position, field width and the bit value for set.
//   out_rsp : valid/ready response channel carrying result and range_error;
//             one response per request, in request order.
//   A request is captured into the input register on acceptance; the
//   datapath computes on it combinationally and the result is loaded into
//   the output register, which presents the response. Throughput is one
//   request per cycle while out_rsp.ready stays high: each stage advances
//   whenever the stage after it is empty or is handing its request on in
//   the same cycle.
//   When the receiver stalls, the response holds in the output register, the
//   input register fills behind it, and in_req.ready then drops until
//   out_rsp.ready returns. No request is dropped or repeated.
//   Reset (rst_n low, synchronous) empties both stages; there is no other
//   state. A range violation gives result zero with range_error set.
// ----------------------------------------------------------------------------
module bit_field_alu
  import bfa_pkg::*;
(
  input  wire       clk,
  input  wire       rst_n,
  bfa_in_if.sink    in_req,
  bfa_out_if.source out_rsp
);

  bfa_req_t s1_req_r;
  bfa_req_t s1_req_nxt;
  logic     s1_valid_r;
  bfa_rsp_t out_rsp_r;
  bfa_rsp_t exec_rsp;
  logic     out_valid_r;
  logic     s1_ready;
  logic     s2_ready;

  assign s2_ready = !out_valid_r || out_rsp.ready;
  assign s1_ready = !s1_valid_r || s2_ready;

  assign s1_req_nxt = '{
    func:         in_req.func,
    wide:         in_req.wide,
    operand_a:    in_req.operand_a,
    operand_b:    in_req.operand_b,
    bit_position: in_req.bit_position,
    field_width:  in_req.field_width,
    bit_value:    in_req.bit_value
  };

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (s1_ready) begin
        s1_valid_r <= in_req.valid;
      end
      if (s2_ready) begin
        out_valid_r <= s1_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_req.valid && s1_ready) begin
      s1_req_r <= s1_req_nxt;
    end
    if (s1_valid_r && s2_ready) begin
      out_rsp_r <= exec_rsp;
    end
  end

  bfa_exec u_exec (
    .req (s1_req_r),
    .rsp (exec_rsp)
  );

  assign in_req.ready        = s1_ready;
  assign out_rsp.valid       = out_valid_r;
  assign out_rsp.result      = out_rsp_r.result;
  assign out_rsp.range_error = out_rsp_r.range_error;

`ifndef SYNTHESIS
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_rsp_r.range_error |-> out_rsp_r.result == '0)
    else $error("response with range_error carries a nonzero result");

  a_s1_advance: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && s2_ready |=> out_valid_r)
    else $error("request lost between input and output register");

  a_in_capture: assert property (@(posedge clk) disable iff (!rst_n)
    in_req.valid && in_req.ready |=> s1_valid_r)
    else $error("accepted request not held in input register");

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_rsp.ready && s1_valid_r |-> !in_req.ready)
    else $error("input accepted while both stages are full and stalled");
`endif

endmodule
`default_nettype wire

// ===== hw/rtl/bfa_exec.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// bfa_exec
// Combinational datapath: range checks and all bit operations for one
// request, selected by the operation code.
// ----------------------------------------------------------------------------
module bfa_exec
  import bfa_pkg::*;
(
  input  bfa_req_t req,
  output bfa_rsp_t rsp
);

  logic [WORD_W-1:0] a;
  logic [WORD_W-1:0] b;
  logic [WORD_W-1:0] wmask;
  logic [POS_W-1:0]  ws;
  logic [5:0]        sh;
  logic              a_bad;
  logic              b_bad;
  logic              p_bad;
  logic              w_bad;
  logic              p_top;
  logic              sar_bad;
  logic [WORD_W-1:0] bit1;
  logic [WORD_W-1:0] low_m;
  logic [WORD_W-1:0] fmask;
  logic [WORD_W-1:0] sext;
  logic [WORD_W-1:0] shr_val;
  logic [WORD_W-1:0] sar_val;
  logic [WORD_W-1:0] res;
  logic              err;

  assign a       = req.operand_a;
  assign b       = req.operand_b;
  assign ws      = req.wide ? POS_W'(WORD_W) : POS_W'(HALF_W);
  assign wmask   = req.wide ? {WORD_W{1'b1}} : {{(WORD_W-HALF_W){1'b0}}, {HALF_W{1'b1}}};
  assign sh      = req.bit_position[5:0];
  assign a_bad   = |(a & ~wmask);
  assign b_bad   = |(b & ~wmask);
  assign p_bad   = req.bit_position > ws;
  assign w_bad   = req.field_width > ws;
  assign p_top   = req.bit_position >= ws;
  assign sext    = {{(WORD_W-HALF_W){a[HALF_W-1]}}, a[HALF_W-1:0]};
  assign sar_bad = !req.wide && (sext != a);
  assign bit1    = WORD_W'(1) << sh;
  // field mask: width ones, moved to position, cut at the word top
  assign low_m   = req.field_width[6] ? {WORD_W{1'b1}}
                                      : (WORD_W'(1) << req.field_width[5:0]) - WORD_W'(1);
  assign fmask   = (low_m << sh) & wmask;
  assign shr_val = a >> sh;
  assign sar_val = WORD_W'($signed(a) >>> sh);

  always_comb begin
    err = 1'b0;
    res = '0;
    unique case (bfa_func_t'(req.func))
      FN_AND: begin
        err = a_bad || b_bad;
        res = a & b;
      end
      FN_OR: begin
        err = a_bad || b_bad;
        res = a | b;
      end
      FN_XOR: begin
        err = a_bad || b_bad;
        res = a ^ b;
      end
      FN_NOT: begin
        err = a_bad;
        res = ~a & wmask;
      end
      FN_COUNT: begin
        err = a_bad;
        res = WORD_W'($countones(a));
      end
      FN_EXTRACT: begin
        err = a_bad || p_bad || w_bad;
        res = p_top ? '0 : (shr_val & low_m);
      end
      FN_GET: begin
        err = a_bad || p_bad;
        res = p_top ? '0 : {{(WORD_W-1){1'b0}}, shr_val[0]};
      end
      FN_SET: begin
        err = a_bad || p_bad;
        if (p_top) begin
          res = a;
        end else if (req.bit_value) begin
          res = a | bit1;
        end else begin
          res = a & ~bit1;
        end
      end
      FN_REPLACE: begin
        err = a_bad || b_bad || p_bad || w_bad;
        res = p_top ? a : ((a & ~fmask) | ((b << sh) & fmask));
      end
      FN_SHL: begin
        err = a_bad || p_bad;
        res = p_top ? '0 : ((a << sh) & wmask);
      end
      FN_SHR: begin
        err = a_bad || p_bad;
        res = p_top ? '0 : shr_val;
      end
      FN_SAR: begin
        err = sar_bad || p_bad;
        res = p_top ? '0 : sar_val;
      end
      default: begin
        err = 1'b1;
        res = '0;
      end
    endcase
  end

  // drop the result on any range violation
  assign rsp.result      = err ? '0 : res;
  assign rsp.range_error = err;

endmodule
`default_nettype wire
